/* rtl/ssh_pkg.sv */
// ssh_pkg: shared types, constants and functions of the SHA-256 stream hasher.
// Depends on nothing; ssh_core, ssh_ctrl and the top level refer to it by scoped names.
`default_nettype none

package ssh_pkg;

	localparam int unsigned WORDS_PER_BLOCK = 16;
	localparam int unsigned ROUNDS          = 64;
	localparam int unsigned CHAIN_WORDS     = 8;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] BLOCK_END = 6'd63;
	localparam logic [2:0] LAST_IDX  = 3'd7;

	localparam logic [31:0] INIT_HASH [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// control from the sequencer to the compression datapath
	typedef struct packed {
		logic       load;    // copy chain value into working variables
		logic       round;   // run one compression round
		logic       update;  // fold working variables into chain value
		logic       reinit;  // reload initial hash values
		logic [5:0] rnd;     // current round number
		logic [2:0] idx;     // digest word being shown
	} ctl_t;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

`default_nettype wire

/* rtl/ssh_if.sv */
// ssh_in_if / ssh_out_if: valid-ready channels of the hasher, message side and digest side.
// Depends on nothing.
`default_nettype none

interface ssh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_valid,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_valid,
		input end_of_message, output ready);
endinterface

interface ssh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/ssh_block_mem.sv */
// ssh_block_mem: 16 x 32-bit block buffer, one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
`default_nettype none

module ssh_block_mem (
	input  logic        clk,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [0:15];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/ssh_core.sv */
// ssh_core: compression datapath - chain value, working variables, schedule window.
// Depends on ssh_pkg (round constants, sigma functions, ctl_t).
`default_nettype none

module ssh_core (
	input  logic          clk,
	input  logic          arst_n,
	input  ssh_pkg::ctl_t ctl,
	input  logic [31:0]   blk_word,
	output logic [31:0]   digest_word
);

	logic [31:0] chain_q [0:7];
	logic [31:0] wv_q    [0:7];
	logic [31:0] wnd_q   [0:15];   // oldest schedule word at 0
	logic [31:0] wt, t1, t2, ch, maj;

	always_comb begin
		if (ctl.rnd < 6'd16) begin
			wt = blk_word;
		end else begin
			wt = ssh_pkg::sig1(wnd_q[14]) + wnd_q[9] + ssh_pkg::sig0(wnd_q[1]) + wnd_q[0];
		end
		ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t1  = wv_q[7] + ssh_pkg::bsig1(wv_q[4]) + ch + ssh_pkg::ROUND_K[ctl.rnd] + wt;
		t2  = ssh_pkg::bsig0(wv_q[0]) + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= ssh_pkg::INIT_HASH[i];
		end else if (ctl.reinit) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= ssh_pkg::INIT_HASH[i];
		end else if (ctl.update) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
		end else if (ctl.round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
			// advance the schedule window
			for (int i = 0; i < 15; i++) wnd_q[i] <= wnd_q[i + 1];
			wnd_q[15] <= wt;
		end
	end

	assign digest_word = chain_q[ctl.idx];

endmodule

`default_nettype wire

/* rtl/ssh_ctrl.sv */
// ssh_ctrl: sequencer - byte packing, padding, length count, round count, digest output.
// Depends on ssh_pkg (constants, ctl_t).
`default_nettype none

module ssh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          byte_valid,
	input  logic          end_of_message,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          mem_we,
	output logic [3:0]    mem_waddr,
	output logic [31:0]   mem_wdata,
	output logic [3:0]    mem_raddr,
	output ssh_pkg::ctl_t ctl
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAD    = 3'd1;
	localparam logic [2:0] ST_CINIT  = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [23:0] word_q;
	logic        pad_q, mark_q, tail_q, final_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;

	logic        accept, wr_en, len_slot, out_done;
	logic [63:0] len_bits;
	logic [7:0]  len_byte, wr_byte;

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		accept    = in_valid && in_ready;
		out_done  = out_valid && out_ready && (idx_q == ssh_pkg::LAST_IDX);
		wr_en     = (accept && byte_valid) || (state_q == ST_PAD);
		len_bits  = {len_q, 3'b000};
		len_byte  = len_bits[{~fill_q[2:0], 3'b000} +: 8];
		len_slot  = mark_q && !tail_q && (fill_q >= ssh_pkg::LEN_POS);
		if (state_q != ST_PAD) begin
			wr_byte = data_byte;
		end else if (!mark_q) begin
			wr_byte = ssh_pkg::PAD_MARK;
		end else if (len_slot) begin
			wr_byte = len_byte;
		end else begin
			wr_byte = 8'h00;
		end
		mem_we    = wr_en && (fill_q[1:0] == 2'b11);
		mem_waddr = fill_q[5:2];
		mem_wdata = {word_q, wr_byte};
		mem_raddr = (state_q == ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;
		ctl.load   = (state_q == ST_CINIT);
		ctl.round  = (state_q == ST_ROUND);
		ctl.update = (state_q == ST_UPDATE);
		ctl.reinit = out_done;
		ctl.rnd    = rnd_q;
		ctl.idx    = idx_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_q <= {word_q[15:0], wr_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			len_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			tail_q  <= 1'b0;
			final_q <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (byte_valid) begin
							len_q <= len_q + 61'd1;
						end
						pad_q <= end_of_message;
						if (byte_valid && fill_q == ssh_pkg::BLOCK_END) begin
							state_q <= ST_CINIT;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (fill_q == ssh_pkg::BLOCK_END) begin
						tail_q  <= 1'b0;
						final_q <= len_slot;
						state_q <= ST_CINIT;
					end else if (!mark_q) begin
						// marker in the tail: length goes into a further block
						tail_q <= (fill_q >= ssh_pkg::LEN_POS);
					end
				end
				ST_CINIT: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ssh_pkg::ROUNDS - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					idx_q <= '0;
					if (final_q) begin
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_valid && out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (out_done) begin
							len_q   <= '0;
							pad_q   <= 1'b0;
							mark_q  <= 1'b0;
							tail_q  <= 1'b0;
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher_unit.sv */
// SHA-256 stream hasher: one message byte per word in, eight digest words out.
// Throughput: a byte word is taken each cycle while idle; every 64th byte holds the
// input for the load, 64 rounds of the single round unit and the chain update.
// End of message: padding bytes go in one per cycle through the same block memory path,
// then one or two compressions, then eight digest words, one per output handshake.
// Reset (arst_n low, asynchronous): counters and sequencer clear, chain value loads the
// initial hash values; the block memory is not cleared and needs no clearing pass.
`default_nettype none

module sha256_stream_hasher_unit (
	input  logic     clk,
	input  logic     arst_n,
	ssh_in_if.sink   msg,
	ssh_out_if.source digest
);

	ssh_pkg::ctl_t ctl;
	logic          mem_we;
	logic [3:0]    mem_waddr;
	logic [31:0]   mem_wdata;
	logic [3:0]    mem_raddr;
	logic [31:0]   mem_rdata;
	logic          out_valid;
	logic [31:0]   chain_word;

	// Sequencer: packs bytes into big-endian words, inserts the 0x80 marker, zero
	// fill and bit length, counts rounds and steps through the digest words.
	ssh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (msg.valid),
		.in_ready       (msg.ready),
		.data_byte      (msg.data_byte),
		.byte_valid     (msg.byte_valid),
		.end_of_message (msg.end_of_message),
		.out_valid      (out_valid),
		.out_ready      (digest.ready),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.ctl            (ctl)
	);

	// Block buffer: written only while bytes come in, its read data used only in rounds 0..15,
	// so the sequencer's states keep the two access kinds apart.
	ssh_block_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Round unit with chain value and schedule window.
	ssh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.blk_word    (mem_rdata),
		.digest_word (chain_word)
	);

	// Digest words come straight from the chain registers, which hold until the
	// last word is taken.
	assign digest.valid       = out_valid;
	assign digest.digest_word = chain_word;
	assign digest.word_index  = ctl.idx;
	assign digest.last_word   = (ctl.idx == ssh_pkg::LAST_IDX);

endmodule

`default_nettype wire

/* rtl/ssh_checker.sv */
// ssh_checker: port-level assertions for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_unit (bind target).
`default_nettype none

module ssh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// a stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest word changed while stalled");

	// no message word is taken while the digest is being shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during digest output");

	// words of one digest follow in order without a gap
	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
			out_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest word sequence broken");

	// after the last word the block returns to taking input
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid && in_ready)
		else $error("block did not return to idle after digest");

endmodule

bind sha256_stream_hasher_unit ssh_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (msg.ready),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.word_index  (digest.word_index),
	.last_word   (digest.last_word)
);

`default_nettype wire
